// ===== src/quoted_argument_tokenizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// quoted argument tokenizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define QAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define QAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== src/qat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_pkg
// types and constants of the quoted argument tokenizer
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int CFG_LINE_W   = 15;
    localparam int CFG_TOKEN_W  = 13;
    localparam int CFG_TOKENS_W = 9;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int RES_MAX      = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [CFG_LINE_W-1:0]   LINE_BYTES_RST  = 15'd16384;
    localparam logic [CFG_TOKEN_W-1:0]  TOKEN_BYTES_RST = 13'd4096;
    localparam logic [CFG_TOKENS_W-1:0] TOKENS_RST      = 9'd256;

    typedef enum logic [1:0] {
        REG_LINE_BYTES  = 2'd0,
        REG_TOKEN_BYTES = 2'd1,
        REG_TOKENS      = 2'd2
    } reg_idx_t;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_TOKEN  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_LINE_LONG   = 3'd1;
    localparam logic [2:0] ST_TOO_MANY    = 3'd2;
    localparam logic [2:0] ST_TOKEN_LONG  = 3'd3;
    localparam logic [2:0] ST_TRAIL_ESC   = 3'd4;
    localparam logic [2:0] ST_OPEN_QUOTE  = 3'd5;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_present;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  token_char;
        logic [7:0]  token_number;
        logic [12:0] token_size;
        logic [2:0]  line_status;
        logic [8:0]  token_total;
        logic [14:0] raw_args_offset;
        logic        last_of_run;
    } out_item_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== src/quoted_argument_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// shell-style tokenizer: splits a byte stream into tokens with quotes and
// escapes, reports line status, token count and raw argument offset
// ----------------------------------------------------------------------------
//  channel   signals                          width      direction
//  in        in_valid / in_ready / in_item    10 bits    request in
//  out       out_valid / out_ready / out_item 59 bits    request out
//  cfg       psel penable pwrite paddr pwdata 4/32 bits  APB write, read
//
//  one request is taken per cycle while in_ready is high; a byte gives at most
//  one result, a line end up to three; results leave through a four-entry queue,
//  one per cycle while out_ready is high. in_ready is high while the queue holds
//  at most one result, so a request giving two or more results holds in_ready
//  low until the queue drains back to at most one result
//  rst_n empties the queue, clears the line state and loads reset values into the limit registers
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer_top
    import qat_pkg::*;
#(
    parameter int LINE_MAX   = 16384,
    parameter int TOKEN_MAX  = 4096,
    parameter int TOKENS_MAX = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int LCW = $clog2(LINE_MAX + 2);
    localparam int LXW = (LCW > CFG_LINE_W) ? LCW : CFG_LINE_W;
    localparam int TCW = $clog2(TOKEN_MAX + 1);
    localparam int TXW = (TCW > CFG_TOKEN_W) ? TCW : CFG_TOKEN_W;
    localparam int NCW = $clog2(TOKENS_MAX + 1);
    localparam int NXW = (NCW > CFG_TOKENS_W) ? NCW : CFG_TOKENS_W;

    logic [CFG_LINE_W-1:0]   cfg_line_reg;
    logic [CFG_TOKEN_W-1:0]  cfg_token_reg;
    logic [CFG_TOKENS_W-1:0] cfg_tokens_reg;
    reg_idx_t                cfg_idx;
    logic                    cfg_wr;

    logic           in_tok_reg, in_tok_next;
    logic [1:0]     quote_reg, quote_next;
    logic           esc_reg, esc_next;
    logic [TCW-1:0] tlen_reg, tlen_next;
    logic [NCW-1:0] tcnt_reg, tcnt_next;
    logic [LCW-1:0] llen_reg, llen_next;
    logic [2:0]     err_reg, err_next;
    logic           seek_reg, seek_next;
    logic [14:0]    raw_reg, raw_next;

    logic [LXW-1:0] line_lim;
    logic [TXW-1:0] tok_lim;
    logic [NXW-1:0] tokens_lim;

    out_item_t         res [RES_MAX];
    logic [1:0]        res_n;
    logic              in_fire;
    logic              pop;

    out_item_t         q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QCNT_W-1:0] cnt_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_line_reg   <= LINE_BYTES_RST;
            cfg_token_reg  <= TOKEN_BYTES_RST;
            cfg_tokens_reg <= TOKENS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LINE_BYTES:  cfg_line_reg   <= pwdata[CFG_LINE_W-1:0];
                REG_TOKEN_BYTES: cfg_token_reg  <= pwdata[CFG_TOKEN_W-1:0];
                REG_TOKENS:      cfg_tokens_reg <= pwdata[CFG_TOKENS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LINE_BYTES:  prdata = PDATA_W'(cfg_line_reg);
            REG_TOKEN_BYTES: prdata = PDATA_W'(cfg_token_reg);
            REG_TOKENS:      prdata = PDATA_W'(cfg_tokens_reg);
            default:         prdata = '0;
        endcase
    end

    // effective limits
    assign line_lim   = (LXW'(cfg_line_reg) < LXW'(LINE_MAX)) ?
                        LXW'(cfg_line_reg) : LXW'(LINE_MAX);
    assign tok_lim    = (TXW'(cfg_token_reg) < TXW'(TOKEN_MAX)) ?
                        TXW'(cfg_token_reg) : TXW'(TOKEN_MAX);
    assign tokens_lim = (NXW'(cfg_tokens_reg) < NXW'(TOKENS_MAX)) ?
                        NXW'(cfg_tokens_reg) : NXW'(TOKENS_MAX);

    assign in_ready = (cnt_reg <= QCNT_W'(1));
    assign in_fire  = in_valid && in_ready;

    // per-byte scan and line-end handling
    always_comb
    begin
        logic [LCW-1:0] pos;
        logic           go;
        logic           do_app;
        logic           do_fin;
        logic [7:0]     c;
        logic [7:0]     q_ch;
        logic [2:0]     status;

        in_tok_next = in_tok_reg;
        quote_next  = quote_reg;
        esc_next    = esc_reg;
        tlen_next   = tlen_reg;
        tcnt_next   = tcnt_reg;
        llen_next   = llen_reg;
        err_next    = err_reg;
        seek_next   = seek_reg;
        raw_next    = raw_reg;
        res_n       = 2'd0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            res[k] = '0;
        end
        pos    = llen_reg;
        go     = 1'b0;
        do_app = 1'b0;
        do_fin = 1'b0;
        c      = in_item.char_byte;
        q_ch   = (quote_reg == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        status = ST_OK;

        if (in_fire && in_item.byte_present)
        begin
            if (LXW'(llen_reg) <= line_lim)
            begin
                llen_next = llen_reg + LCW'(1);
            end
            if ((LXW'(llen_next) <= line_lim) && (err_reg == ST_OK))
            begin
                go = 1'b1;
                if (!in_tok_reg)
                begin
                    if (is_space(c))
                    begin
                        go = 1'b0;
                    end
                    else
                    begin
                        if (seek_reg)
                        begin
                            raw_next  = 15'(pos);
                            seek_next = 1'b0;
                        end
                        if (NXW'(tcnt_reg) >= tokens_lim)
                        begin
                            err_next = ST_TOO_MANY;
                            go       = 1'b0;
                        end
                        else
                        begin
                            in_tok_next = 1'b1;
                            tlen_next   = '0;
                        end
                    end
                end
                if (go)
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        do_app   = 1'b1;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (quote_reg != QUOTE_NONE)
                    begin
                        if (c == q_ch)
                        begin
                            quote_next = QUOTE_NONE;
                        end
                        else
                        begin
                            do_app = 1'b1;
                        end
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        quote_next = QUOTE_SINGLE;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        quote_next = QUOTE_DOUBLE;
                    end
                    else if (is_space(c))
                    begin
                        do_fin = 1'b1;
                    end
                    else
                    begin
                        do_app = 1'b1;
                    end
                end
                if (do_app)
                begin
                    if (TXW'(tlen_next) >= tok_lim)
                    begin
                        err_next = ST_TOKEN_LONG;
                    end
                    else
                    begin
                        tlen_next                = tlen_next + TCW'(1);
                        res[res_n].kind          = KIND_BYTE;
                        res[res_n].token_char    = c;
                        res[res_n].token_number  = 8'(tcnt_reg);
                        res_n                    = res_n + 2'd1;
                    end
                end
                if (do_fin)
                begin
                    res[res_n].kind         = KIND_TOKEN;
                    res[res_n].token_number = 8'(tcnt_reg);
                    res[res_n].token_size   = 13'(tlen_next);
                    res_n                   = res_n + 2'd1;
                    tcnt_next               = tcnt_reg + NCW'(1);
                    in_tok_next             = 1'b0;
                    tlen_next               = '0;
                    if (tcnt_next == NCW'(1))
                    begin
                        seek_next = 1'b1;
                    end
                end
            end
        end

        if (in_fire && in_item.line_end)
        begin
            if (LXW'(llen_next) > line_lim)
            begin
                status = ST_LINE_LONG;
            end
            else
            begin
                if ((err_next == ST_OK) && in_tok_next)
                begin
                    if (esc_next)
                    begin
                        err_next = ST_TRAIL_ESC;
                    end
                    else if (quote_next != QUOTE_NONE)
                    begin
                        err_next = ST_OPEN_QUOTE;
                    end
                    else
                    begin
                        res[res_n].kind         = KIND_TOKEN;
                        res[res_n].token_number = 8'(tcnt_next);
                        res[res_n].token_size   = 13'(tlen_next);
                        res_n                   = res_n + 2'd1;
                        tcnt_next               = tcnt_next + NCW'(1);
                        if (tcnt_next == NCW'(1))
                        begin
                            seek_next = 1'b1;
                        end
                    end
                end
                if (seek_next)
                begin
                    raw_next = 15'(llen_next);
                end
                status = err_next;
            end
            res[res_n].kind        = KIND_STATUS;
            res[res_n].line_status = status;
            if (status == ST_OK)
            begin
                res[res_n].token_total     = 9'(tcnt_next);
                res[res_n].raw_args_offset = raw_next;
            end
            res_n       = res_n + 2'd1;
            in_tok_next = 1'b0;
            quote_next  = QUOTE_NONE;
            esc_next    = 1'b0;
            tlen_next   = '0;
            tcnt_next   = '0;
            llen_next   = '0;
            err_next    = ST_OK;
            seek_next   = 1'b0;
            raw_next    = '0;
        end

        if (res_n != 2'd0)
        begin
            res[2'(res_n - 2'd1)].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tok_reg <= 1'b0;
            quote_reg  <= QUOTE_NONE;
            esc_reg    <= 1'b0;
            tlen_reg   <= '0;
            tcnt_reg   <= '0;
            llen_reg   <= '0;
            err_reg    <= ST_OK;
            seek_reg   <= 1'b0;
            raw_reg    <= '0;
        end
        else
        begin
            in_tok_reg <= in_tok_next;
            quote_reg  <= quote_next;
            esc_reg    <= esc_next;
            tlen_reg   <= tlen_next;
            tcnt_reg   <= tcnt_next;
            llen_reg   <= llen_next;
            err_reg    <= err_next;
            seek_reg   <= seek_next;
            raw_reg    <= raw_next;
        end
    end

    // result queue
    assign out_valid = (cnt_reg != '0);
    assign out_item  = q_mem[head_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_MAX; k++)
        begin
            if (2'(k) < res_n)
            begin
                q_mem[tail_reg + QPTR_W'(k)] <= res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_reg + QPTR_W'(pop);
            tail_reg <= tail_reg + QPTR_W'(res_n);
            cnt_reg  <= cnt_reg - QCNT_W'(pop) + QCNT_W'(res_n);
        end
    end

endmodule

// ===== src/qat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_checker
// port-level checks of the quoted argument tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "quoted_argument_tokenizer_top_assert.svh"

module qat_checker
    import qat_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item,
    input logic      pready
);

    logic st_valid;
    logic st_failed;
    logic fail_clean;
    logic byte_valid;
    logic byte_clean;

    assign st_valid   = out_valid && (out_item.kind == KIND_STATUS);
    assign st_failed  = st_valid && (out_item.line_status != ST_OK);
    assign fail_clean = (out_item.token_total == '0) && (out_item.raw_args_offset == '0);
    assign byte_valid = out_valid && (out_item.kind == KIND_BYTE);
    assign byte_clean = (out_item.token_size == '0) && (out_item.line_status == ST_OK);

    // a status request always closes its run
    `QAT_ASSERT_NOW(a_status_last, st_valid, out_item.last_of_run)

    // a failed line carries no count and no offset
    `QAT_ASSERT_NOW(a_err_no_total, st_failed, fail_clean)

    // token bytes never close a line and carry no size
    `QAT_ASSERT_NOW(a_byte_fields, byte_valid, byte_clean)

    // a stalled result holds
    `QAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // register port never waits
    `QAT_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind quoted_argument_tokenizer_top qat_checker u_qat_checker (.*);
